// ----- hdl/sida_pkg.sv -----
package sida_pkg;

    localparam int SYMBOL_BUFFER = 20;
    localparam int MAX_PLACES    = SYMBOL_BUFFER - 2;
    localparam int POS_W         = $clog2(SYMBOL_BUFFER);

    localparam int VALUE_W       = 32;
    localparam int PLACES_W      = 5;
    localparam int CHAR_W        = 7;

    localparam int DIGITS        = 10;
    localparam int DIGIT_W       = $clog2(DIGITS);
    localparam int CONV_CYCLES   = VALUE_W;
    localparam int CNT_W         = $clog2(CONV_CYCLES);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 7'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  value;
        logic        [PLACES_W-1:0] decimal_places;
    } num_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } chr_t;

endpackage

// ----- hdl/signed_int_to_decimal_ascii_fixed_point.sv -----
// Channel | Signals                       | Item
// --------+-------------------------------+------------------------------------------
// num     | num_valid, num_ready, num     | signed value and count of decimal places
// chr     | chr_valid, chr_ready, chr     | one ASCII character and its last flag
//
// An item is converted to BCD by a shift-and-add-3 unit, then a sizing step finds the
// leading digit, then one character leaves per cycle while chr_ready is high.
// num_ready is high only while the sequencer is idle; the last character may still
// wait in the output register while the next item is taken.
// Reset is asynchronous and clears the sequencer and the output valid flag.
// A low chr_ready holds the current character and pauses the emission.
module signed_int_to_decimal_ascii_fixed_point (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           num_valid,
    output logic           num_ready,
    input  sida_pkg::num_t num,
    output logic           chr_valid,
    input  logic           chr_ready,
    output sida_pkg::chr_t chr
);
    import sida_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SIZE = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [3:0]         bcd_reg [DIGITS];
    logic [3:0]         bcd_next [DIGITS];
    logic [3:0]         bcd_adj [DIGITS];
    logic               neg_reg, neg_next;
    logic [POS_W-1:0]   places_reg, places_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               dot_reg, dot_next;
    logic               out_valid_reg, out_valid_next;
    chr_t               out_reg, out_next;

    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] mag;
    logic [POS_W-1:0]   top_idx;
    logic [3:0]         digit_sel;
    logic               accept;
    logic               load_out;

    assign num_ready = (state_reg == ST_IDLE);
    assign accept    = num_valid && num_ready;
    assign chr_valid = out_valid_reg;
    assign chr       = out_reg;
    assign load_out  = (state_reg == ST_EMIT) && (!out_valid_reg || chr_ready);

    assign raw = num.value;
    assign mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? (bcd_reg[i] + 4'd3) : bcd_reg[i];
        end
    end

    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                top_idx = POS_W'(i);
            end
        end
    end

    always_comb
    begin
        if (pos_reg < POS_W'(DIGITS))
        begin
            digit_sel = bcd_reg[pos_reg[DIGIT_W-1:0]];
        end
        else
        begin
            digit_sel = 4'd0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        places_next    = places_reg;
        pos_next       = pos_reg;
        dot_next       = dot_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && chr_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next = raw[VALUE_W-1];
                    bin_next = mag;
                    cnt_next = '0;
                    for (int i = 0; i < DIGITS; i++)
                    begin
                        bcd_next[i] = 4'd0;
                    end
                    if (num.decimal_places > PLACES_W'(MAX_PLACES))
                    begin
                        places_next = POS_W'(MAX_PLACES);
                    end
                    else
                    begin
                        places_next = POS_W'(num.decimal_places);
                    end
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next[0] = {bcd_adj[0][2:0], bin_reg[VALUE_W-1]};
                for (int i = 1; i < DIGITS; i++)
                begin
                    bcd_next[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
                end
                bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CONV_CYCLES - 1))
                begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                pos_next   = (top_idx > places_reg) ? top_idx : places_reg;
                dot_next   = 1'b0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    if (neg_reg)
                    begin
                        out_next.character = CHAR_MINUS;
                        out_next.last      = 1'b0;
                        neg_next           = 1'b0;
                    end
                    else if (dot_reg)
                    begin
                        out_next.character = CHAR_POINT;
                        out_next.last      = 1'b0;
                        dot_next           = 1'b0;
                    end
                    else
                    begin
                        out_next.character = CHAR_ZERO + {3'b000, digit_sel};
                        out_next.last      = (pos_reg == '0);
                        if ((places_reg != '0) && (pos_reg == places_reg))
                        begin
                            dot_next = 1'b1;
                        end
                        if (pos_reg == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            pos_next = pos_reg - 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg    <= bin_next;
        bcd_reg    <= bcd_next;
        neg_reg    <= neg_next;
        places_reg <= places_next;
        pos_reg    <= pos_next;
        dot_reg    <= dot_next;
        out_reg    <= out_next;
    end

endmodule

// ----- hdl/sida_checker.sv -----
module sida_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           num_valid,
    input logic           num_ready,
    input sida_pkg::num_t num,
    input logic           chr_valid,
    input logic           chr_ready,
    input sida_pkg::chr_t chr
);
    import sida_pkg::*;

    // A stalled character holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        chr_valid && !chr_ready |=> chr_valid && $stable(chr))
        else $error("character changed or dropped while stalled");

    // The block works on one item at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        num_valid && num_ready |=> !num_ready)
        else $error("new item taken while converting");

    // While a character other than the last is shown, no new item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        chr_valid && !chr.last |-> !num_ready)
        else $error("ready while a number is still being emitted");

    // A decimal point is always followed by a digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        chr_valid && (chr.character == CHAR_POINT) |-> !chr.last)
        else $error("decimal point flagged as last character");

endmodule

bind signed_int_to_decimal_ascii_fixed_point sida_checker u_sida_checker (.*);

// ----- verif/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sida_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_CYCLES = 100;

    logic clk;
    logic rst_n = 1'b0;
    logic num_valid = 1'b0;
    logic num_ready;
    num_t num = '0;
    logic chr_valid;
    logic chr_ready = 1'b0;
    chr_t chr;

    num_t pending_nums[$];
    chr_t pending_chars[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit num_fire = 1'b0;
    bit chr_fire = 1'b0;
    int idle_cycles = 0;
    int errors = 0;
    int numbers_taken = 0;
    int chars_checked = 0;
    int negatives_taken = 0;
    int clamped_taken = 0;

    signed_int_to_decimal_ascii_fixed_point dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (num_valid),
        .num_ready (num_ready),
        .num       (num),
        .chr_valid (chr_valid),
        .chr_ready (chr_ready),
        .chr       (chr)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Builds the expected text of one number, least significant symbol first,
    // then queues it most significant first with the last flag on the final one.
    function automatic void render_number(num_t item);
        logic [VALUE_W-1:0] mag;
        logic [CHAR_W-1:0] symbols [SYMBOL_BUFFER];
        int places;
        int countdown;
        int count;
        chr_t expect_chr;
        mag = item.value;
        if (item.value[VALUE_W-1])
            mag = ~mag + 1'b1;
        places = item.decimal_places;
        if (places > MAX_PLACES)
            places = MAX_PLACES;
        countdown = (places != 0) ? places + 1 : 0;
        count = 0;
        while (mag != 0 || count == 0 || countdown != 0)
        begin
            if (countdown != 0)
            begin
                countdown--;
                if (countdown == 0)
                begin
                    if (count >= SYMBOL_BUFFER)
                        break;
                    symbols[count] = CHAR_POINT;
                    count++;
                end
            end
            if (count >= SYMBOL_BUFFER)
                break;
            symbols[count] = CHAR_ZERO + CHAR_W'(mag % 32'd10);
            count++;
            mag = mag / 32'd10;
        end
        if (item.value[VALUE_W-1])
        begin
            expect_chr.character = CHAR_MINUS;
            expect_chr.last = 1'b0;
            pending_chars.push_back(expect_chr);
        end
        for (int i = count - 1; i >= 0; i--)
        begin
            expect_chr.character = symbols[i];
            expect_chr.last = (i == 0);
            pending_chars.push_back(expect_chr);
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        chr_t want;
        num_fire = rst_n && num_valid && num_ready;
        chr_fire = rst_n && chr_valid && chr_ready;
        if (num_fire)
        begin
            render_number(num);
            numbers_taken++;
            if (num.value < 0)
                negatives_taken++;
            if (num.decimal_places > MAX_PLACES)
                clamped_taken++;
        end
        if (chr_fire)
        begin
            chars_checked++;
            if (pending_chars.size() == 0)
            begin
                $error("character: expected none, got %h (last %b)", chr.character, chr.last);
                errors++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (chr.character !== want.character)
                begin
                    $error("character: expected %h, got %h", want.character, chr.character);
                    errors++;
                end
                if (chr.last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, chr.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (num_valid && num_ready) || (chr_valid && chr_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            num_valid <= 1'b0;
        else if (num_valid && !num_fire)
            ;
        else if (pending_nums.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            num <= pending_nums.pop_front();
            num_valid <= 1'b1;
        end
        else
            num_valid <= 1'b0;
    end

    always @(negedge clk)
    begin
        chr_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void queue_number(longint value, int places);
        num_t item;
        item.value = VALUE_W'(value);
        item.decimal_places = PLACES_W'(places);
        pending_nums.push_back(item);
    endfunction

    task automatic queue_random(int count);
        longint value;
        longint power;
        int places;
        repeat (count)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3: value = $signed($urandom);
                4, 5: value = longint'($urandom_range(2000)) - 1000;
                6, 7:
                begin
                    power = 1;
                    repeat ($urandom_range(9))
                        power = power * 10;
                    value = power + longint'($urandom_range(2)) - 1;
                    if ($urandom_range(1))
                        value = -value;
                end
                default: value = $urandom_range(1) ? 64'sd2147483647 : -64'sd2147483648;
            endcase
            if ($urandom_range(4) == 0)
                places = $urandom_range(31);
            else
                places = $urandom_range(MAX_PLACES);
            queue_number(value, places);
        end
    endtask

    // The sender stays quiet until every character of the queued numbers is back.
    task automatic drain();
        while (pending_nums.size() != 0 || num_valid || pending_chars.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_number(0, 0);
        queue_number(0, 18);
        queue_number(0, 31);
        queue_number(1, 0);
        queue_number(-1, 0);
        queue_number(7, 1);
        queue_number(-7, 1);
        queue_number(5, 3);
        queue_number(-5, 3);
        queue_number(123456, 2);
        queue_number(-123456, 2);
        queue_number(1000, 3);
        queue_number(2147483647, 0);
        queue_number(-2147483648, 0);
        queue_number(2147483647, 18);
        queue_number(-2147483648, 18);
        queue_number(-2147483648, 31);
        queue_number(2147483647, 19);
        queue_number(999999999, 9);
        queue_number(1000000000, 10);
        queue_number(-1000000000, 9);
        queue_number(42, 16);
        queue_number(-1, 17);
        queue_number(10, 21);
        queue_number(-99, 24);
        queue_random(60);
        drain();

        send_idle_pct = 48;
        recv_stall_pct = 0;
        queue_random(70);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 48;
        queue_random(70);
        drain();

        send_idle_pct = 25;
        recv_stall_pct = 25;
        queue_random(70);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Rendered %0d numbers (%0d negative, %0d with clamped place counts)",
                 numbers_taken, negatives_taken, clamped_taken);
        $display("Checked %0d characters across four sender and receiver stall mixes",
                 chars_checked);
        if (errors == 0 && pending_chars.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
